// File: rtl/ascii_frame_scanner_defines.svh
// Assertion macros for the ASCII frame scanner.
// Taken in by ascii_frame_scanner.sv, which carries the concurrent assertions; no dependencies.
`ifndef ASCII_FRAME_SCANNER_DEFINES_SVH
`define ASCII_FRAME_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define AFS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ascii_frame_scanner: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define AFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ascii_frame_scanner: next-cycle check failed");

`endif

// File: rtl/afs_pkg.sv
// Package of the ASCII frame scanner: character codes, end markers, state type, hex test.
// No dependencies; used by ascii_frame_scanner.sv.
`default_nettype none

package afs_pkg;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // End markers accepted in the open frame.
   localparam logic [1:0] EM_NONE = 2'd0;
   localparam logic [1:0] EM_CR   = 2'd1;

   typedef enum logic {
      ST_SCAN,
      ST_EMIT
   } state_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
   endfunction

endpackage

`default_nettype wire

// File: rtl/ascii_frame_scanner.sv
// Top level of the ASCII frame scanner: scan logic, frame store and read-out.
// Depends on afs_pkg.sv and ascii_frame_scanner_defines.svh.
`default_nettype none
`include "ascii_frame_scanner_defines.svh"

// The scanner takes one received byte per item on the req_ channel and looks
// for frames of the form colon, hex digits, CR, LF. A colon opens a new frame
// unless the store is full or a datagram tail is being ignored; any other byte
// that breaks the grammar abandons the frame and is dropped. Bytes of the open
// frame are written to a frame store of FRAME_DEPTH entries. While scanning, a
// byte is taken every cycle. When the closing LF is taken, req_tready falls and
// the stored frame is read back through the store's single read port, one byte
// per cycle unless the rsp_ side stalls, and offered on the rsp_ channel with
// rsp_tlast on the LF; req_tready rises again in the cycle after the last read
// is issued. A byte arriving while the store already holds FRAME_DEPTH bytes
// abandons the frame, and the rest of its datagram (up to and including the
// byte with req_tlast set) is then ignored. The store needs no clearing after
// reset: only entries of the current frame are ever read.
module ascii_frame_scanner #(
   parameter int FRAME_DEPTH = 64
) (
   input  wire        clock,
   input  wire        reset,
   // Received bytes.
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] rx_byte
   input  wire        req_tlast,   // datagram_end
   // Completed frames, one character per item.
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] frame_char
   output logic       rsp_tlast    // frame_last
);

   localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FRAME_DEPTH);

   // Scan state.
   afs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   frame_count_ff, frame_count_in;
   logic               in_frame_ff, in_frame_in;
   logic [1:0]         end_markers_ff, end_markers_in;
   logic               drop_rest_ff, drop_rest_in;

   // Read-out control.
   logic [CNT_W-1:0]   emit_len_ff, emit_len_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [7:0]         rd_data_ff;
   logic               rd_last_ff, rd_last_in;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   // Frame store.
   logic [7:0]         frame_store_ff [FRAME_DEPTH];
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic               rd_issue;
   logic               rd_move;
   logic               start_emit;
   logic               emit_active;
   logic               req_take;

   assign req_take = req_tvalid && req_tready;

   // -----------------------------------------------------------------------
   // Scan logic: decides, for each byte taken, whether it is stored, whether
   // it closes the frame and what becomes of the scan state.
   // -----------------------------------------------------------------------
   always_comb begin
      frame_count_in = frame_count_ff;
      in_frame_in    = in_frame_ff;
      end_markers_in = end_markers_ff;
      drop_rest_in   = drop_rest_ff;
      mem_we         = 1'b0;
      mem_waddr      = frame_count_ff[ADDR_W-1:0];
      start_emit     = 1'b0;
      emit_len_in    = emit_len_ff;

      if (req_take) begin
         if (drop_rest_ff) begin
            // Ignoring the tail of a datagram that overflowed the store.
            if (req_tlast) begin
               drop_rest_in = 1'b0;
            end
         end else if (in_frame_ff && (frame_count_ff == DEPTH_CNT)) begin
            // Store full: abandon the frame, even for a colon.
            in_frame_in    = 1'b0;
            end_markers_in = afs_pkg::EM_NONE;
            frame_count_in = '0;
            drop_rest_in   = !req_tlast;
         end else if (req_tdata == afs_pkg::CH_COLON) begin
            // A colon opens a fresh frame and is its first byte.
            mem_we         = 1'b1;
            mem_waddr      = '0;
            in_frame_in    = 1'b1;
            end_markers_in = afs_pkg::EM_NONE;
            frame_count_in = CNT_W'(1);
         end else if (in_frame_ff && (req_tdata == afs_pkg::CH_CR) &&
                      (end_markers_ff == afs_pkg::EM_NONE)) begin
            mem_we         = 1'b1;
            end_markers_in = afs_pkg::EM_CR;
            frame_count_in = CNT_W'(frame_count_ff + 1'b1);
         end else if (in_frame_ff && (req_tdata == afs_pkg::CH_LF) &&
                      (end_markers_ff == afs_pkg::EM_CR)) begin
            // Closing LF: store it, hand the frame length to the read-out
            // and leave the scanner ready for the next frame.
            mem_we         = 1'b1;
            start_emit     = 1'b1;
            emit_len_in    = CNT_W'(frame_count_ff + 1'b1);
            in_frame_in    = 1'b0;
            end_markers_in = afs_pkg::EM_NONE;
            frame_count_in = '0;
         end else if (in_frame_ff && afs_pkg::is_hex(req_tdata) &&
                      (end_markers_ff == afs_pkg::EM_NONE)) begin
            mem_we         = 1'b1;
            frame_count_in = CNT_W'(frame_count_ff + 1'b1);
         end else begin
            // Grammar break: the byte is dropped and the frame abandoned.
            in_frame_in    = 1'b0;
            end_markers_in = afs_pkg::EM_NONE;
            frame_count_in = '0;
         end
      end
   end

   // -----------------------------------------------------------------------
   // State machine: next state.
   // -----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         afs_pkg::ST_SCAN: begin
            if (start_emit) begin
               state_in = afs_pkg::ST_EMIT;
            end
         end
         afs_pkg::ST_EMIT: begin
            if (rd_issue && rd_last_in) begin
               state_in = afs_pkg::ST_SCAN;
            end
         end
         default: state_in = afs_pkg::ST_SCAN;
      endcase
   end

   // State machine: outputs. Input is held off while the store is read out,
   // so a write and a read of the store never fall in the same cycle.
   always_comb begin
      req_tready  = 1'b0;
      emit_active = 1'b0;
      unique case (state_ff)
         afs_pkg::ST_SCAN: req_tready  = 1'b1;
         afs_pkg::ST_EMIT: emit_active = 1'b1;
         default: begin
            req_tready  = 1'b0;
            emit_active = 1'b0;
         end
      endcase
   end

   // -----------------------------------------------------------------------
   // Read-out pipeline: store read register, then output register. The read
   // register holds its byte in an output stall; a new read is issued only
   // as that byte moves on, so one byte a cycle flows when not stalled.
   // -----------------------------------------------------------------------
   assign rd_move  = rd_pend_ff && (!out_valid_ff || rsp_tready);
   assign rd_issue = emit_active && (!rd_pend_ff || rd_move);

   always_comb begin
      rd_last_in = (rd_idx_ff == CNT_W'(emit_len_ff - 1'b1));
      rd_pend_in = rd_issue || (rd_pend_ff && !rd_move);
      rd_idx_in  = rd_idx_ff;
      if (start_emit) begin
         rd_idx_in = '0;
      end else if (rd_issue) begin
         rd_idx_in = CNT_W'(rd_idx_ff + 1'b1);
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (rd_move) begin
         out_valid_in = 1'b1;
         out_data_in  = rd_data_ff;
         out_last_in  = rd_last_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // Frame store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store_ff[mem_waddr] <= req_tdata;
      end
      if (rd_issue) begin
         rd_data_ff <= frame_store_ff[rd_idx_ff[ADDR_W-1:0]];
         rd_last_ff <= rd_last_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      emit_len_ff <= emit_len_in;
      rd_idx_ff   <= rd_idx_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= afs_pkg::ST_SCAN;
         frame_count_ff <= '0;
         in_frame_ff    <= 1'b0;
         end_markers_ff <= afs_pkg::EM_NONE;
         drop_rest_ff   <= 1'b0;
         rd_pend_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         in_frame_ff    <= in_frame_in;
         end_markers_ff <= end_markers_in;
         drop_rest_ff   <= drop_rest_in;
         rd_pend_ff     <= rd_pend_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // -----------------------------------------------------------------------
   // Assertions.
   // -----------------------------------------------------------------------
   `AFS_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, frame_count_ff <= DEPTH_CNT)
   `AFS_ASSERT_NOW(a_idle_scan_clear, clock, reset, !in_frame_ff,
                   (frame_count_ff == '0) && (end_markers_ff == afs_pkg::EM_NONE))
   `AFS_ASSERT_NOW(a_no_write_in_emit, clock, reset, mem_we, !emit_active && !rd_issue)
   `AFS_ASSERT_NEXT(a_stalled_read_held, clock, reset,
                    rd_pend_ff && out_valid_ff && !rsp_tready,
                    rd_pend_ff && $stable(rd_data_ff))

endmodule

`default_nettype wire
